[rtl/fddc_pkg.sv]
// shared types, codes and constants for the floppy dma controller
`timescale 1ns / 1ps
package fddc_pkg;

  typedef enum logic [2:0] {
    ACT_PTR_HI   = 3'd0,
    ACT_PTR_LO   = 3'd1,
    ACT_SYNC     = 3'd2,
    ACT_CTRL     = 3'd3,
    ACT_LENGTH   = 3'd4,
    ACT_BYTE_RD  = 3'd5,
    ACT_DATA_RD  = 3'd6,
    ACT_GRANT    = 3'd7
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] value;
    logic        media_ready;
    logic        track_has_sync;
    logic [15:0] disk_word;
    logic [31:0] tick_cycles;
    logic        is_tick;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        ram_write;
    logic [31:0] ram_address;
    logic [15:0] ram_data;
    logic        irq_sync;
    logic        irq_block;
    logic        wants_service;
    logic [31:0] cycles_to_event;
  } rsp_item_t;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int FAKE_W     = 24;

  localparam logic REG_SYNC_IRQ_EN = 1'b0;
  localparam logic REG_FAKE_CYCLES = 1'b1;

  localparam logic [15:0]     SYNC_RESET      = 16'h4489;
  localparam logic [FAKE_W-1:0] FAKE_RESET    = 24'd4096;
  localparam logic [15:0]     STAT_WORDSYNC   = 16'h1000;
  localparam logic [15:0]     STAT_DMAON      = 16'h4000;
  localparam int              CTRL_WORDSYNC_BIT = 10;

endpackage

[rtl/fddc_if.sv]
// valid/ready channel interfaces for command and response transfers
`timescale 1ns / 1ps
interface fddc_cmd_if;
  logic                  valid;
  logic                  ready;
  fddc_pkg::cmd_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fddc_rsp_if;
  logic                  valid;
  logic                  ready;
  fddc_pkg::rsp_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/floppy_disk_dma_controller_top.sv]
// floppy read-dma controller with sync word detection, top level
//
//  channel | dir | handshake            | payload
//  cmd     | in  | valid/ready          | action, value, media/sync flags, word, tick
//  rsp     | out | valid/ready          | read data, ram write, irqs, service, countdown
//  apb     | in  | psel/penable/pready  | sync irq enable, fake dma cycles
//
// one command per cycle; each transfer is decoded against the register state in
// the cycle it is accepted and its response lands in the output register
// reset (rst, synchronous) clears state, sync word to 0x4489, fake count to 4096
// a held response stalls cmd only when rsp.ready is low and the register is full
`timescale 1ns / 1ps
module floppy_disk_dma_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  fddc_cmd_if.sink                            cmd,
  fddc_rsp_if.source                          rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fddc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [fddc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fddc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import fddc_pkg::*;

  logic              sync_irq_enable;
  logic [FAKE_W-1:0] fake_dma_cycles;

  logic [31:0]       disk_pointer, disk_pointer_next;
  logic [15:0]       sync_word, sync_word_next;
  logic [14:0]       control_bits, control_bits_next;
  logic [15:0]       data_latch, data_latch_next;
  logic [8:0]        byte_latch, byte_latch_next;
  logic              dma_run, dma_run_next;
  logic              dma_primed, dma_primed_next;
  logic              wr_dir, wr_dir_next;
  logic              sync_found, sync_found_next;
  logic              sync_irq_taken, sync_irq_taken_next;
  logic [FAKE_W-1:0] countdown, countdown_next;
  logic [31:0]       transfer_base, transfer_base_next;
  logic [14:0]       bytes_total, bytes_total_next;
  logic [14:0]       bytes_done, bytes_done_next;

  logic              rsp_valid;
  rsp_item_t         rsp_data, rsp_data_next;
  logic              cmd_fire;
  logic              apb_write;

  function automatic logic [1:0] sync_try(input logic seen, input logic wsync,
                                          input logic fired, input logic en);
    logic [1:0] r;
    r = {fired, 1'b0};
    if (seen && wsync && !fired) begin
      r = {1'b1, en};
    end
    return r;
  endfunction

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_FAKE_CYCLES) ?
                     {{(APB_DATA_W-FAKE_W){1'b0}}, fake_dma_cycles} :
                     {{(APB_DATA_W-1){1'b0}}, sync_irq_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_irq_enable <= 1'b1;
      fake_dma_cycles <= FAKE_RESET;
    end else if (apb_write) begin
      case (paddr[2])
        REG_SYNC_IRQ_EN: sync_irq_enable <= pwdata[0];
        REG_FAKE_CYCLES: fake_dma_cycles <= pwdata[FAKE_W-1:0];
        default:         sync_irq_enable <= sync_irq_enable;
      endcase
    end
  end

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    logic [1:0]  t;
    logic        irq_s;
    logic        irq_b;
    logic [15:0] rd;
    logic        ramw;
    logic [31:0] addr;
    logic [15:0] rdata;
    logic [14:0] mask;
    logic        wsync;
    logic [13:0] words;

    disk_pointer_next   = disk_pointer;
    sync_word_next      = sync_word;
    control_bits_next   = control_bits;
    data_latch_next     = data_latch;
    byte_latch_next     = byte_latch;
    dma_run_next        = dma_run;
    dma_primed_next     = dma_primed;
    wr_dir_next         = wr_dir;
    sync_found_next     = sync_found;
    sync_irq_taken_next = sync_irq_taken;
    countdown_next      = countdown;
    transfer_base_next  = transfer_base;
    bytes_total_next    = bytes_total;
    bytes_done_next     = bytes_done;
    irq_s = 1'b0;
    irq_b = 1'b0;
    rd    = '0;
    ramw  = 1'b0;
    addr  = '0;
    rdata = '0;
    t     = '0;
    mask  = cmd.data.value[14:0];
    words = cmd.data.value[13:0];
    wsync = control_bits[CTRL_WORDSYNC_BIT];

    if (cmd.data.is_tick) begin
      if (dma_run && bytes_total == '0 && countdown != '0) begin
        if ({{(32-FAKE_W){1'b0}}, countdown} > cmd.data.tick_cycles) begin
          countdown_next = countdown - cmd.data.tick_cycles[FAKE_W-1:0];
        end else begin
          countdown_next      = '0;
          dma_run_next        = 1'b0;
          dma_primed_next     = 1'b0;
          sync_found_next     = 1'b0;
          sync_irq_taken_next = 1'b0;
          irq_b               = 1'b1;
        end
      end
    end else begin
      case (action_t'(cmd.data.action))
        ACT_PTR_HI: disk_pointer_next = {cmd.data.value, disk_pointer[15:0]};
        ACT_PTR_LO: disk_pointer_next = {disk_pointer[31:16], cmd.data.value};
        ACT_SYNC: begin
          sync_word_next = cmd.data.value;
          t = sync_try(sync_found, control_bits[CTRL_WORDSYNC_BIT], 1'b0,
                       sync_irq_enable);
          sync_irq_taken_next = t[1];
          irq_s = t[0];
        end
        ACT_CTRL: begin
          if (cmd.data.value[15]) begin
            control_bits_next = control_bits | mask;
          end else begin
            control_bits_next = control_bits & ~mask;
          end
          t = sync_try(sync_found, control_bits_next[CTRL_WORDSYNC_BIT],
                       sync_irq_taken, sync_irq_enable);
          sync_irq_taken_next = t[1];
          irq_s = t[0];
        end
        ACT_LENGTH: begin
          if (!cmd.data.value[15]) begin
            dma_run_next        = 1'b0;
            dma_primed_next     = 1'b0;
            countdown_next      = '0;
            sync_found_next     = 1'b0;
            sync_irq_taken_next = 1'b0;
            byte_latch_next     = '0;
          end else if (!dma_primed) begin
            dma_primed_next = 1'b1;
          end else begin
            wr_dir_next         = cmd.data.value[14];
            dma_run_next        = 1'b1;
            dma_primed_next     = 1'b0;
            sync_found_next     = 1'b0;
            sync_irq_taken_next = 1'b0;
            byte_latch_next     = '0;
            countdown_next      = '0;
            data_latch_next     = '0;
            transfer_base_next  = disk_pointer;
            bytes_total_next    = '0;
            bytes_done_next     = '0;
            if (!cmd.data.value[14] && words != '0) begin
              if (!cmd.data.media_ready) begin
                countdown_next = fake_dma_cycles;
              end else begin
                if (cmd.data.track_has_sync) begin
                  byte_latch_next = {1'b1, sync_word[7:0]};
                  data_latch_next = sync_word;
                  sync_found_next = 1'b1;
                end
                t = sync_try(sync_found_next, control_bits[CTRL_WORDSYNC_BIT], 1'b0,
                             sync_irq_enable);
                sync_irq_taken_next = t[1];
                irq_s = t[0];
                bytes_total_next = {words, 1'b0};
              end
            end
          end
        end
        ACT_BYTE_RD: begin
          rd = {byte_latch[8], 7'b0, byte_latch[7:0]};
          if (sync_found) begin
            rd = rd | STAT_WORDSYNC;
          end
          if (dma_run) begin
            rd = rd | STAT_DMAON;
          end
          byte_latch_next = {1'b0, byte_latch[7:0]};
        end
        ACT_DATA_RD: rd = data_latch;
        ACT_GRANT: begin
          if (dma_run && !wr_dir && bytes_done < bytes_total) begin
            ramw  = 1'b1;
            addr  = transfer_base + {17'b0, bytes_done};
            rdata = cmd.data.disk_word;
            byte_latch_next = {1'b1, cmd.data.disk_word[7:0]};
            data_latch_next = cmd.data.disk_word;
            if (cmd.data.disk_word == sync_word) begin
              sync_found_next = 1'b1;
              t = sync_try(1'b1, wsync, sync_irq_taken, sync_irq_enable);
              sync_irq_taken_next = t[1];
              irq_s = t[0];
            end
            bytes_done_next = bytes_done + 15'd2;
            if (bytes_done_next >= bytes_total) begin
              if (sync_found_next) begin
                t = sync_try(1'b1, wsync, 1'b0, sync_irq_enable);
                irq_s = irq_s | t[0];
              end
              dma_run_next        = 1'b0;
              dma_primed_next     = 1'b0;
              sync_found_next     = 1'b0;
              sync_irq_taken_next = 1'b0;
              disk_pointer_next   = transfer_base + {17'b0, bytes_total};
              irq_b               = 1'b1;
            end
          end
        end
        default: rd = '0;
      endcase
    end

    rsp_data_next.read_data     = rd;
    rsp_data_next.ram_write     = ramw;
    rsp_data_next.ram_address   = addr;
    rsp_data_next.ram_data      = rdata;
    rsp_data_next.irq_sync      = irq_s;
    rsp_data_next.irq_block     = irq_b;
    rsp_data_next.wants_service = dma_run_next && !wr_dir_next &&
                                  (bytes_done_next < bytes_total_next);
    rsp_data_next.cycles_to_event = '1;
    if (dma_run_next && countdown_next != '0 && bytes_total_next == '0) begin
      rsp_data_next.cycles_to_event = {{(32-FAKE_W){1'b0}}, countdown_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_pointer   <= '0;
      sync_word      <= SYNC_RESET;
      control_bits   <= '0;
      data_latch     <= '0;
      byte_latch     <= '0;
      dma_run        <= 1'b0;
      dma_primed     <= 1'b0;
      wr_dir         <= 1'b0;
      sync_found     <= 1'b0;
      sync_irq_taken <= 1'b0;
      countdown      <= '0;
      transfer_base  <= '0;
      bytes_total    <= '0;
      bytes_done     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cmd_fire) begin
        disk_pointer   <= disk_pointer_next;
        sync_word      <= sync_word_next;
        control_bits   <= control_bits_next;
        data_latch     <= data_latch_next;
        byte_latch     <= byte_latch_next;
        dma_run        <= dma_run_next;
        dma_primed     <= dma_primed_next;
        wr_dir         <= wr_dir_next;
        sync_found     <= sync_found_next;
        sync_irq_taken <= sync_irq_taken_next;
        countdown      <= countdown_next;
        transfer_base  <= transfer_base_next;
        bytes_total    <= bytes_total_next;
        bytes_done     <= bytes_done_next;
        rsp_valid      <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

[rtl/fddc_checker.sv]
// port-level checks for the floppy dma controller, bound to the top level
`timescale 1ns / 1ps
module fddc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] read_data,
  input logic        ram_write,
  input logic        irq_block,
  input logic        wants_service,
  input logic [31:0] cycles_to_event,
  input logic [31:0] ram_address
);

  // a stalled transfer keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(ram_address) &&
    $stable(read_data))
    else $error("response changed while stalled");

  // a memory write never carries read data or a countdown
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ram_write |-> read_data == 16'h0 && cycles_to_event == 32'hffffffff)
    else $error("memory write with read data or countdown");

  // block done leaves nothing to service
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && irq_block |-> !wants_service && cycles_to_event == 32'hffffffff)
    else $error("block done while dma still busy");

  // a transfer in progress has no fake countdown
  a_service_no_cd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && wants_service |-> cycles_to_event == 32'hffffffff)
    else $error("countdown shown during transfer");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind floppy_disk_dma_controller_top fddc_checker u_fddc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .read_data       (rsp.data.read_data),
  .ram_write       (rsp.data.ram_write),
  .irq_block       (rsp.data.irq_block),
  .wants_service   (rsp.data.wants_service),
  .cycles_to_event (rsp.data.cycles_to_event),
  .ram_address     (rsp.data.ram_address)
);

[bench/tb_top.sv]
// self-checking bench for the floppy read-dma controller: directed and random transfers
`timescale 1ns / 1ps
module tb_top;
  import fddc_pkg::*;

  localparam int TIMEOUT_NS = 2_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 200;
  localparam logic [15:0] LEN_ENABLE = 16'h8000;
  localparam logic [15:0] LEN_WRITE = 16'h4000;
  localparam logic [15:0] CTRL_SET = 16'h8000;
  localparam logic [15:0] CTRL_WORDSYNC = 16'h0400;
  localparam logic [15:0] LATCH_READ_MASK = 16'h80ff;
  localparam logic [13:0] MAX_WORDS = 14'h3fff;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  fddc_cmd_if cmd_if();
  fddc_rsp_if rsp_if();

  floppy_disk_dma_controller_top DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // controller state as predicted
  bit cfg_sync_en;
  logic [FAKE_W-1:0] cfg_fake;
  logic [31:0] disk_ptr;
  logic [15:0] sync_wd;
  logic [14:0] ctrl_bits;
  logic [15:0] data_lat;
  logic [15:0] byte_lat;
  bit dma_on;
  bit dma_primed;
  bit wr_mode;
  bit sync_found;
  bit sync_fired;
  logic [31:0] countdown;
  logic [31:0] xfer_base;
  logic [14:0] bytes_total;
  logic [14:0] bytes_done;
  bit irq_sync_now;

  rsp_item_t expected_rsp[$];
  int mismatches = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic void clear_controller_state();
    cfg_sync_en = 1'b1;
    cfg_fake = FAKE_RESET;
    disk_ptr = '0;
    sync_wd = SYNC_RESET;
    ctrl_bits = '0;
    data_lat = '0;
    byte_lat = '0;
    dma_on = 1'b0;
    dma_primed = 1'b0;
    wr_mode = 1'b0;
    sync_found = 1'b0;
    sync_fired = 1'b0;
    countdown = '0;
    xfer_base = '0;
    bytes_total = '0;
    bytes_done = '0;
  endfunction

  function automatic void raise_sync_if_due();
    if (!sync_found || !ctrl_bits[CTRL_WORDSYNC_BIT] || sync_fired) return;
    sync_fired = 1'b1;
    if (cfg_sync_en) irq_sync_now = 1'b1;
  endfunction

  function automatic void load_latches(logic [15:0] w);
    byte_lat = {8'h80, w[7:0]};
    data_lat = w;
  endfunction

  function automatic bit service_wanted();
    return dma_on && !wr_mode && (bytes_done < bytes_total);
  endfunction

  function automatic void end_block();
    dma_on = 1'b0;
    dma_primed = 1'b0;
    sync_found = 1'b0;
    sync_fired = 1'b0;
  endfunction

  function automatic rsp_item_t step_controller(cmd_item_t c);
    rsp_item_t r;
    logic [13:0] words;
    r = '0;
    irq_sync_now = 1'b0;
    if (c.is_tick) begin
      if (dma_on && bytes_total == 0 && countdown != 0) begin
        if (countdown > c.tick_cycles) begin
          countdown = countdown - c.tick_cycles;
        end else begin
          countdown = '0;
          end_block();
          r.irq_block = 1'b1;
        end
      end
    end else begin
      case (action_t'(c.action))
        ACT_PTR_HI: disk_ptr[31:16] = c.value;
        ACT_PTR_LO: disk_ptr[15:0] = c.value;
        ACT_SYNC: begin
          sync_wd = c.value;
          sync_fired = 1'b0;
          raise_sync_if_due();
        end
        ACT_CTRL: begin
          if (c.value[15]) ctrl_bits = ctrl_bits | c.value[14:0];
          else ctrl_bits = ctrl_bits & ~c.value[14:0];
          raise_sync_if_due();
        end
        ACT_LENGTH: begin
          if (!c.value[15]) begin
            dma_on = 1'b0;
            dma_primed = 1'b0;
            countdown = '0;
            sync_found = 1'b0;
            sync_fired = 1'b0;
            byte_lat = '0;
          end else if (!dma_primed) begin
            dma_primed = 1'b1;
          end else begin
            words = c.value[13:0];
            wr_mode = c.value[14];
            dma_on = 1'b1;
            dma_primed = 1'b0;
            sync_found = 1'b0;
            sync_fired = 1'b0;
            byte_lat = '0;
            countdown = '0;
            data_lat = '0;
            xfer_base = disk_ptr;
            bytes_total = '0;
            bytes_done = '0;
            if (!wr_mode && words != 0) begin
              if (!c.media_ready) begin
                countdown = {8'h00, cfg_fake};
              end else begin
                if (c.track_has_sync) begin
                  load_latches(sync_wd);
                  sync_found = 1'b1;
                end
                raise_sync_if_due();
                bytes_total = {words, 1'b0};
              end
            end
          end
        end
        ACT_BYTE_RD: begin
          r.read_data = byte_lat & LATCH_READ_MASK;
          if (sync_found) r.read_data = r.read_data | STAT_WORDSYNC;
          if (dma_on) r.read_data = r.read_data | STAT_DMAON;
          byte_lat[15] = 1'b0;
        end
        ACT_DATA_RD: r.read_data = data_lat;
        ACT_GRANT: begin
          if (service_wanted()) begin
            r.ram_write = 1'b1;
            r.ram_address = xfer_base + 32'(bytes_done);
            r.ram_data = c.disk_word;
            load_latches(c.disk_word);
            if (c.disk_word == sync_wd) begin
              sync_found = 1'b1;
              raise_sync_if_due();
            end
            bytes_done = bytes_done + 15'd2;
            if (bytes_done >= bytes_total) begin
              if (sync_found) begin
                sync_fired = 1'b0;
                raise_sync_if_due();
              end
              end_block();
              disk_ptr = xfer_base + 32'(bytes_total);
              r.irq_block = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.irq_sync = irq_sync_now;
    r.wants_service = service_wanted();
    r.cycles_to_event = (dma_on && countdown > 0 && bytes_total == 0) ? countdown : '1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic compare_rsp(input rsp_item_t got, input rsp_item_t want);
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
    if (got.ram_write !== want.ram_write)
      report_mismatch("ram_write", 32'(got.ram_write), 32'(want.ram_write));
    if (got.ram_address !== want.ram_address)
      report_mismatch("ram_address", got.ram_address, want.ram_address);
    if (got.ram_data !== want.ram_data)
      report_mismatch("ram_data", 32'(got.ram_data), 32'(want.ram_data));
    if (got.irq_sync !== want.irq_sync)
      report_mismatch("irq_sync", 32'(got.irq_sync), 32'(want.irq_sync));
    if (got.irq_block !== want.irq_block)
      report_mismatch("irq_block", 32'(got.irq_block), 32'(want.irq_block));
    if (got.wants_service !== want.wants_service)
      report_mismatch("wants_service", 32'(got.wants_service), 32'(want.wants_service));
    if (got.cycles_to_event !== want.cycles_to_event)
      report_mismatch("cycles_to_event", got.cycles_to_event, want.cycles_to_event);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) report_mismatch("response with none pending", '0, '0);
      else compare_rsp(rsp_if.data, expected_rsp.pop_front());
    end
  end

  // response side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_item(input cmd_item_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    expected_rsp.push_back(step_controller(c));
    items_sent++;
  endtask

  task automatic drain_idle();
    cmd_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic idx, input logic [31:0] val);
    logic [31:0] kept;
    logic [31:0] readback;
    drain_idle();
    kept = (idx == REG_FAKE_CYCLES) ? {8'h00, val[FAKE_W-1:0]} : {31'h0, val[0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_FAKE_CYCLES) cfg_fake = val[FAKE_W-1:0];
    else cfg_sync_en = val[0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== kept) report_mismatch("register readback", readback, kept);
  endtask

  function automatic cmd_item_t make_item(action_t act, logic [15:0] val);
    cmd_item_t c;
    c.action = act;
    c.value = val;
    c.media_ready = 1'($urandom_range(0, 1));
    c.track_has_sync = 1'($urandom_range(0, 1));
    c.disk_word = 16'($urandom);
    c.tick_cycles = $urandom;
    c.is_tick = 1'b0;
    return c;
  endfunction

  function automatic cmd_item_t make_start(logic [15:0] val, bit media, bit has_sync);
    cmd_item_t c;
    c = make_item(ACT_LENGTH, val);
    c.media_ready = media;
    c.track_has_sync = has_sync;
    return c;
  endfunction

  function automatic cmd_item_t make_grant(logic [15:0] w);
    cmd_item_t c;
    c = make_item(ACT_GRANT, 16'($urandom));
    c.disk_word = w;
    return c;
  endfunction

  function automatic cmd_item_t make_tick(logic [31:0] cyc);
    cmd_item_t c;
    c = make_item(action_t'(3'($urandom)), 16'($urandom));
    c.is_tick = 1'b1;
    c.tick_cycles = cyc;
    return c;
  endfunction

  function automatic cmd_item_t make_noise();
    cmd_item_t c;
    c = make_item(action_t'(3'($urandom)), 16'($urandom));
    c.is_tick = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  // disable, then arm; the next enabling length write starts the block
  task automatic arm_dma();
    send_item(make_item(ACT_LENGTH, 16'($urandom) & ~LEN_ENABLE));
    send_item(make_item(ACT_LENGTH, LEN_ENABLE | 16'($urandom)));
  endtask

  task automatic test_register_access();
    send_item(make_item(ACT_BYTE_RD, 16'h0000));
    send_item(make_item(ACT_DATA_RD, 16'hffff));
    send_item(make_item(ACT_PTR_HI, 16'hffff));
    send_item(make_item(ACT_PTR_LO, 16'h0000));
    send_item(make_item(ACT_CTRL, 16'hffff));
    send_item(make_item(ACT_CTRL, 16'h7fff));
    send_item(make_item(ACT_SYNC, 16'hffff));
    send_item(make_grant(16'hffff));
    send_item(make_tick(32'hffff_ffff));
  endtask

  // block that wraps the address and sees the sync word at start and on the track
  task automatic test_read_block();
    send_item(make_item(ACT_PTR_LO, 16'hfffe));
    send_item(make_item(ACT_SYNC, SYNC_RESET));
    send_item(make_item(ACT_CTRL, CTRL_SET | CTRL_WORDSYNC));
    arm_dma();
    send_item(make_start(LEN_ENABLE | 16'd2, 1'b1, 1'b1));
    send_item(make_grant(SYNC_RESET));
    send_item(make_item(ACT_BYTE_RD, 16'h0000));
    send_item(make_item(ACT_DATA_RD, 16'h0000));
    send_item(make_grant(16'h0000));
  endtask

  task automatic test_zero_count();
    arm_dma();
    send_item(make_start(LEN_ENABLE, 1'b1, 1'b0));
    send_item(make_grant(16'h1234));
    send_item(make_item(ACT_BYTE_RD, 16'h0000));
  endtask

  task automatic test_fake_countdown();
    program_register(REG_FAKE_CYCLES, 32'd3);
    arm_dma();
    send_item(make_start(LEN_ENABLE | {2'b00, MAX_WORDS}, 1'b0, 1'b1));
    send_item(make_tick(32'd0));
    send_item(make_tick(32'd1));
    send_item(make_tick(32'hffff_ffff));
    // a zero count never runs out
    program_register(REG_FAKE_CYCLES, 32'd0);
    arm_dma();
    send_item(make_start(LEN_ENABLE | 16'd1, 1'b0, 1'b0));
    send_item(make_tick(32'hffff_ffff));
  endtask

  task automatic read_block_sequence();
    int words;
    int grants;
    int i;
    if ($urandom_range(0, 1)) send_item(make_item(ACT_PTR_HI, 16'($urandom)));
    if ($urandom_range(0, 1)) send_item(make_item(ACT_PTR_LO, 16'($urandom)));
    if ($urandom_range(0, 2) == 0) send_item(make_item(ACT_SYNC, 16'($urandom)));
    if ($urandom_range(0, 2) == 0) send_item(make_item(ACT_CTRL, 16'($urandom)));
    else send_item(make_item(ACT_CTRL, CTRL_SET | CTRL_WORDSYNC | 16'($urandom)));
    arm_dma();
    if ($urandom_range(0, 19) == 0) begin
      words = MAX_WORDS;
      grants = $urandom_range(1, 8);
    end else begin
      words = $urandom_range(1, 6);
      grants = ($urandom_range(0, 7) == 0) ? $urandom_range(0, words - 1)
                                             : words + $urandom_range(0, 1);
    end
    send_item(make_start(LEN_ENABLE | 16'(words), 1'b1, 1'($urandom_range(0, 1))));
    for (i = 0; i < grants; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(make_item($urandom_range(0, 1) ? ACT_BYTE_RD : ACT_DATA_RD, 16'($urandom)));
      if ($urandom_range(0, 9) == 0) send_item(make_tick($urandom));
      send_item(make_grant(($urandom_range(0, 3) == 0) ? sync_wd : 16'($urandom)));
    end
    if (dma_on) send_item(make_item(ACT_LENGTH, 16'($urandom) & ~LEN_ENABLE));
  endtask

  task automatic fake_block_sequence();
    int i;
    logic [31:0] cyc;
    arm_dma();
    send_item(make_start(LEN_ENABLE | 16'($urandom_range(1, MAX_WORDS)), 1'b0,
                         1'($urandom_range(0, 1))));
    for (i = 0; i < 6 && dma_on; i++) begin
      case ($urandom_range(0, 4))
        0: cyc = '0;
        1: cyc = $urandom_range(1, 100);
        2: cyc = countdown - 1;
        3: cyc = countdown;
        default: cyc = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) send_item(make_item(ACT_BYTE_RD, 16'($urandom)));
      send_item(make_tick(cyc));
    end
    if (dma_on) send_item(make_item(ACT_LENGTH, 16'($urandom) & ~LEN_ENABLE));
  endtask

  task automatic write_dir_sequence();
    int i;
    arm_dma();
    send_item(make_start(LEN_ENABLE | LEN_WRITE | 16'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
    for (i = 0; i < $urandom_range(1, 3); i++) send_item(make_grant(16'($urandom)));
    send_item(make_tick($urandom));
    send_item(make_item(ACT_LENGTH, 16'($urandom) & ~LEN_ENABLE));
  endtask

  task automatic run_traffic(input int n);
    int target;
    int i;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: read_block_sequence();
        5, 6: fake_block_sequence();
        7: write_dir_sequence();
        default: for (i = 0; i < $urandom_range(1, 6); i++) send_item(make_noise());
      endcase
    end
  endtask

  task automatic test_random_traffic();
    program_register(REG_FAKE_CYCLES, {8'h00, 24'hffffff});
    program_register(REG_SYNC_IRQ_EN, 32'd1);
    run_traffic(PHASE_ITEMS);
    program_register(REG_SYNC_IRQ_EN, 32'd0);
    program_register(REG_FAKE_CYCLES, 32'd1);
    run_traffic(PHASE_ITEMS);
    program_register(REG_SYNC_IRQ_EN, 32'd1);
    program_register(REG_FAKE_CYCLES, 32'($urandom_range(2, 64)));
    run_traffic(PHASE_ITEMS);
  endtask

  task automatic test_back_to_back();
    program_register(REG_SYNC_IRQ_EN, 32'($urandom_range(0, 1)));
    program_register(REG_FAKE_CYCLES, 32'($urandom_range(2, 200)));
    idle_on = 1'b0;
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin
    clear_controller_state();
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_read_block();
    test_zero_count();
    test_fake_countdown();
    test_random_traffic();
    test_back_to_back();
    drain_idle();
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
